FILE: hw/rtl/dglr_pkg.sv
`timescale 1ns / 1ps
package dglr_pkg;
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_STAR  = 2'd1;
  localparam logic       CFG_ROWS   = 1'b0;
  localparam logic       CFG_COLS   = 1'b1;
  localparam int         NEIGHBORS  = 8;
  localparam int         RC_W       = 7;
  localparam int         RESULT_W   = 13;
endpackage

FILE: hw/rtl/dglr_ram.sv
`timescale 1ns / 1ps
module dglr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/dilated_grid_largest_region_unit.sv
`timescale 1ns / 1ps
// Loading: one cell transfer per cycle; the cell with last_cell set starts the compute.
// Compute: clear of both maps (N = MAX_ROWS*MAX_COLS entries), marking of the empty
// cells around each star, then flood fill of the marked cells through a queue.
// in_ready stays low from the last cell until the result is taken at out_valid.
// Synchronous active-high reset: both dimension registers to 64, idle, load position 0.
module dilated_grid_largest_region_unit
  import dglr_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [RC_W-1:0]     cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cell_kind,
  input  logic                last_cell,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RESULT_W-1:0] largest_region
);
  localparam int N  = MAX_ROWS * MAX_COLS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int QW = $clog2(N + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_MSCAN, S_MRD, S_MNB, S_MCHK,
    S_FSCAN, S_FRD, S_FPOP, S_FQRD, S_FNB, S_FCHK, S_DONE
  } state_t;
  state_t state;

  logic [RC_W-1:0] row_count, column_count;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [AW:0]   load_position;
  logic [RW-1:0] r, hr;
  logic [CW-1:0] c, hc;
  logic [3:0]    k;
  logic [QW-1:0] head, tail;
  logic [RESULT_W-1:0] region_size, best_size;
  logic [AW-1:0] sweep;

  always_comb begin
    if (row_count == '0) rows = RW'(1);
    else if (32'(row_count) > MAX_ROWS) rows = RW'(MAX_ROWS);
    else rows = RW'(row_count);
    if (column_count == '0) cols = CW'(1);
    else if (32'(column_count) > MAX_COLS) cols = CW'(MAX_COLS);
    else cols = CW'(column_count);
  end

  // neighbor offsets
  logic signed [1:0] dr, dc;
  always_comb begin
    unique case (k[2:0])
      3'd0: begin dr = 2'sd0;  dc = -2'sd1; end
      3'd1: begin dr = 2'sd0;  dc = 2'sd1;  end
      3'd2: begin dr = -2'sd1; dc = -2'sd1; end
      3'd3: begin dr = -2'sd1; dc = 2'sd1;  end
      3'd4: begin dr = -2'sd1; dc = 2'sd0;  end
      3'd5: begin dr = 2'sd1;  dc = -2'sd1; end
      3'd6: begin dr = 2'sd1;  dc = 2'sd0;  end
      default: begin dr = 2'sd1; dc = 2'sd1; end
    endcase
  end

  logic [RW-1:0] br;
  logic [CW-1:0] bc;
  logic signed [RW+1:0] nr;
  logic signed [CW+1:0] nc;
  logic nb_ok;
  assign br = (state == S_MNB || state == S_MCHK) ? r : hr;
  assign bc = (state == S_MNB || state == S_MCHK) ? c : hc;
  assign nr = $signed({2'b00, br}) + (RW+2)'(dr);
  assign nc = $signed({2'b00, bc}) + (CW+2)'(dc);
  assign nb_ok = !nr[RW+1] && !nc[CW+1] && (nr < $signed({2'b00, rows}))
                 && (nc < $signed({2'b00, cols}));

  // address = row*cols + col
  logic [AW-1:0] nb_addr, cur_addr;
  assign nb_addr = AW'(nr[RW-1:0] * cols) + AW'(nc[CW-1:0]);
  assign cur_addr = AW'(r * cols) + AW'(c);

  logic [AW-1:0] nb_reg;
  logic [RW+CW-1:0] nb_rc;
  logic at_end;
  assign at_end = (c == cols - 1'b1) && (r == rows - 1'b1);

  // memories
  logic          cs_we;  logic [AW-1:0] cs_wa, cs_ra; logic [1:0] cs_wd, cs_rd;
  logic          mk_we;  logic [AW-1:0] mk_wa, mk_ra; logic mk_wd, mk_rd;
  logic          vs_we;  logic [AW-1:0] vs_wa, vs_ra; logic vs_wd, vs_rd;
  logic          q_we;   logic [AW-1:0] q_wa, q_ra;   logic [RW+CW-1:0] q_wd, q_rd;

  dglr_ram #(.WIDTH(2), .DEPTH(N)) u_cells (.clk, .we(cs_we), .waddr(cs_wa),
    .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd));
  dglr_ram #(.WIDTH(1), .DEPTH(N)) u_marked (.clk, .we(mk_we), .waddr(mk_wa),
    .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd));
  dglr_ram #(.WIDTH(1), .DEPTH(N)) u_visited (.clk, .we(vs_we), .waddr(vs_wa),
    .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd));
  dglr_ram #(.WIDTH(RW+CW), .DEPTH(N)) u_queue (.clk, .we(q_we), .waddr(q_wa),
    .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic in_xfer;
  logic [AW:0] limit;
  assign limit = (AW+1)'(rows * cols);
  assign in_ready = (state == S_LOAD);
  assign in_xfer = in_valid && in_ready;
  assign cfg_ready = (state == S_LOAD);

  always_comb begin
    cs_we = in_xfer && (load_position < limit);
    cs_wa = load_position[AW-1:0];
    cs_wd = cell_kind;
    cs_ra = (state == S_MSCAN) ? cur_addr : nb_addr;
    mk_we = 1'b0; mk_wa = sweep; mk_wd = 1'b0;
    vs_we = 1'b0; vs_wa = sweep; vs_wd = 1'b0;
    mk_ra = (state == S_FSCAN) ? cur_addr : nb_addr;
    vs_ra = mk_ra;
    q_we = 1'b0; q_wa = tail[AW-1:0]; q_wd = {r, c};
    q_ra = head[AW-1:0];
    unique case (state)
      S_CLEAR: begin mk_we = 1'b1; vs_we = 1'b1; end
      S_MCHK: begin
        mk_we = (cs_rd == KIND_EMPTY); mk_wa = nb_reg; mk_wd = 1'b1;
      end
      S_FRD: begin
        vs_we = 1'b1; vs_wa = cur_addr; vs_wd = 1'b1;
        q_we = mk_rd && !vs_rd; q_wa = '0;
      end
      S_FCHK: begin
        vs_we = 1'b1; vs_wa = nb_reg; vs_wd = 1'b1;
        q_we = mk_rd && !vs_rd; q_wd = nb_rc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      row_count <= RC_W'(64);
      column_count <= RC_W'(64);
      load_position <= '0;
      out_valid <= 1'b0;
      region_size <= '0;
      best_size <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROWS) row_count <= cfg_data;
        else column_count <= cfg_data;
      end
      unique case (state)
        S_LOAD: if (in_xfer) begin
          if (load_position < limit) load_position <= load_position + 1'b1;
          if (last_cell) begin
            state <= S_CLEAR; sweep <= '0; best_size <= '0;
          end
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(N - 1)) begin
            state <= S_MSCAN; r <= '0; c <= '0;
          end
        end
        S_MSCAN: state <= S_MRD;
        S_MRD: begin
          if (cs_rd == KIND_STAR) begin
            k <= '0; state <= S_MNB;
          end else if (at_end) begin
            r <= '0; c <= '0; state <= S_FSCAN;
          end else if (c == cols - 1'b1) begin
            c <= '0; r <= r + 1'b1; state <= S_MSCAN;
          end else begin
            c <= c + 1'b1; state <= S_MSCAN;
          end
        end
        S_MNB: begin
          if (k == 4'(NEIGHBORS)) begin
            if (at_end) begin
              r <= '0; c <= '0; state <= S_FSCAN;
            end else if (c == cols - 1'b1) begin
              c <= '0; r <= r + 1'b1; state <= S_MSCAN;
            end else begin
              c <= c + 1'b1; state <= S_MSCAN;
            end
          end else if (nb_ok) begin
            nb_reg <= nb_addr; state <= S_MCHK;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_MCHK: begin
          k <= k + 1'b1; state <= S_MNB;
        end
        S_FSCAN: state <= S_FRD;
        S_FRD: begin
          if (mk_rd && !vs_rd) begin
            head <= '0; tail <= QW'(1); region_size <= RESULT_W'(1);
            state <= S_FPOP;
          end else if (at_end) begin
            state <= S_DONE; out_valid <= 1'b1;
          end else if (c == cols - 1'b1) begin
            c <= '0; r <= r + 1'b1; state <= S_FSCAN;
          end else begin
            c <= c + 1'b1; state <= S_FSCAN;
          end
        end
        S_FPOP: begin
          if (head == tail) begin
            if (region_size > best_size) best_size <= region_size;
            if (at_end) begin
              state <= S_DONE; out_valid <= 1'b1;
            end else if (c == cols - 1'b1) begin
              c <= '0; r <= r + 1'b1; state <= S_FSCAN;
            end else begin
              c <= c + 1'b1; state <= S_FSCAN;
            end
          end else begin
            state <= S_FQRD;
          end
        end
        S_FQRD: begin
          hr <= q_rd[RW+CW-1:CW];
          hc <= q_rd[CW-1:0];
          head <= head + 1'b1;
          k <= '0;
          state <= S_FNB;
        end
        S_FNB: begin
          if (k == 4'(NEIGHBORS)) begin
            state <= S_FPOP;
          end else if (nb_ok) begin
            nb_reg <= nb_addr; nb_rc <= {nr[RW-1:0], nc[CW-1:0]}; state <= S_FCHK;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FCHK: begin
          if (mk_rd && !vs_rd) begin
            tail <= tail + 1'b1; region_size <= region_size + 1'b1;
          end
          k <= k + 1'b1; state <= S_FNB;
        end
        S_DONE: if (out_ready) begin
          out_valid <= 1'b0; load_position <= '0; state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign largest_region = best_size;
endmodule

FILE: test/dilated_grid_largest_region_unit_tb.sv
`timescale 1ns / 1ps
module dilated_grid_largest_region_unit_tb
  import dglr_pkg::*;
();

  localparam int GRID_MAX = 64;
  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_CELLS = 1300;
  localparam int DUE_DEPTH = 16;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_ODD = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_ROWS;
  logic [RC_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cell_kind = KIND_EMPTY;
  logic last_cell = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RESULT_W-1:0] largest_region;

  dilated_grid_largest_region_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cell_kind(cell_kind),
    .last_cell(last_cell),
    .out_valid(out_valid), .out_ready(out_ready), .largest_region(largest_region)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // grid shadow
  logic [RC_W-1:0] rows_reg = 7'd64;
  logic [RC_W-1:0] cols_reg = 7'd64;
  logic [1:0] grid[CELLS];
  bit written[CELLS];
  int written_prefix = 0;
  int load_pos = 0;
  logic [RESULT_W-1:0] region_due[DUE_DEPTH];
  int due_wr = 0;
  int due_rd = 0;
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic int clamp_dim(logic [RC_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  function automatic logic [RESULT_W-1:0] largest_halo_region();
    int rows, cols, best, size, here, hr, hc, nr, nc, idx, wh, wt;
    int dr[8], dc[8];
    bit halo[CELLS];
    bit seen[CELLS];
    int work[CELLS];
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    dr = '{0, 0, -1, -1, -1, 1, 1, 1};
    dc = '{-1, 1, -1, 1, 0, -1, 0, 1};
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (grid[r*cols+c] == KIND_STAR)
          for (int k = 0; k < NEIGHBORS; k++) begin
            nr = r + dr[k];
            nc = c + dc[k];
            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols &&
                grid[nr*cols+nc] == KIND_EMPTY)
              halo[nr*cols+nc] = 1'b1;
          end
    best = 0;
    for (int s = 0; s < rows * cols; s++) begin
      if (seen[s]) continue;
      seen[s] = 1'b1;
      if (!halo[s]) continue;
      wh = 0;
      wt = 0;
      work[wt] = s;
      wt++;
      size = 1;
      while (wh < wt) begin
        here = work[wh];
        wh++;
        hr = here / cols;
        hc = here % cols;
        for (int k = 0; k < NEIGHBORS; k++) begin
          nr = hr + dr[k];
          nc = hc + dc[k];
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          idx = nr * cols + nc;
          if (halo[idx] && !seen[idx]) begin
            work[wt] = idx;
            wt++;
            size++;
          end
          seen[idx] = 1'b1;
        end
      end
      if (size > best) best = size;
    end
    return RESULT_W'(best);
  endfunction

  // returns 1 when the cell closes a frame and a region size is due
  function automatic bit load_cell(logic [1:0] kind, logic last,
                                   output logic [RESULT_W-1:0] sz);
    int lim;
    lim = clamp_dim(rows_reg) * clamp_dim(cols_reg);
    sz = '0;
    if (load_pos < lim) begin
      grid[load_pos] = kind;
      written[load_pos] = 1'b1;
      while (written_prefix < CELLS && written[written_prefix]) written_prefix++;
      load_pos++;
    end
    if (!last) return 1'b0;
    sz = largest_halo_region();
    load_pos = 0;
    return 1'b1;
  endfunction

  task automatic wait_idle();
    while (due_wr != due_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [RC_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROWS) rows_reg = val;
    else cols_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one cell transfer; typed >= 0 overrides the predicted size
  task automatic send_cell(logic [1:0] kind, logic last, int typed);
    logic [RESULT_W-1:0] sz;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    cell_kind <= kind;
    last_cell <= last;
    do @(posedge clk); while (!in_ready);
    if (load_cell(kind, last, sz)) begin
      region_due[due_wr % DUE_DEPTH] = (typed >= 0) ? RESULT_W'(typed) : sz;
      due_wr++;
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  typedef struct {
    bit is_cfg;
    logic idx;
    logic [RC_W-1:0] val;
    logic [1:0] kind;
    logic last;
    int typed;
  } step_t;

  step_t directed[] = '{
    '{1, CFG_ROWS, 7'd0, KIND_EMPTY, 0, -1},
    '{1, CFG_COLS, 7'd0, KIND_EMPTY, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 1, 0},
    '{0, CFG_ROWS, 7'd0, KIND_EMPTY, 1, 0},
    '{1, CFG_ROWS, 7'd1, KIND_EMPTY, 0, -1},
    '{1, CFG_COLS, 7'd3, KIND_EMPTY, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_EMPTY, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_EMPTY, 1, 1},
    '{0, CFG_ROWS, 7'd0, KIND_ODD, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_EMPTY, 1, 1},
    // too many cells: extras dropped
    '{0, CFG_ROWS, 7'd0, KIND_EMPTY, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_EMPTY, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_OTHER, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 1, -1},
    // too few cells: old contents kept
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 1, -1},
    '{1, CFG_ROWS, 7'd0, KIND_EMPTY, 0, -1},
    '{1, CFG_COLS, 7'd1, KIND_EMPTY, 0, -1},
    '{0, CFG_ROWS, 7'd0, KIND_STAR, 1, 0}
  };

  function automatic logic [RC_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 16) return 7'd127;
    if (r < 26) return 7'd64;
    if (r < 32) return RC_W'($urandom_range(65, 126));
    return RC_W'($urandom_range(1, 12));
  endfunction

  task automatic send_frame();
    int lim, n, star_pct, r;
    logic [1:0] kind;
    lim = clamp_dim(rows_reg) * clamp_dim(cols_reg);
    n = lim;
    r = $urandom_range(0, 99);
    if (r < 8) n = lim + $urandom_range(1, 5);
    else if (r < 16 && written_prefix >= lim && lim > 1) n = $urandom_range(1, lim - 1);
    star_pct = $urandom_range(3, 50);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < star_pct) kind = KIND_STAR;
      else if (r < star_pct + 12) kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_ODD;
      else kind = KIND_EMPTY;
      send_cell(kind, i == n - 1, -1);
    end
  endtask

  initial begin
    int sent;
    logic [RC_W-1:0] rv, cv;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        stop_sending();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_cell(directed[i].kind, directed[i].last, directed[i].typed);
      end
    end
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      rv = pick_dim();
      cv = pick_dim();
      while (clamp_dim(rv) * clamp_dim(cv) > 256) cv = RC_W'($urandom_range(1, 4));
      stop_sending();
      write_reg(CFG_ROWS, rv);
      write_reg(CFG_COLS, cv);
      repeat ($urandom_range(1, 4)) begin
        send_frame();
        sent += clamp_dim(rv) * clamp_dim(cv);
      end
    end
    stop_sending();
    while (due_wr != due_rd) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("[dilated_grid_largest_region_unit] OK");
    else $display("[dilated_grid_largest_region_unit] ERROR");
    $finish;
  end

  // receiver: alternating free-flow and random stalls, one long hold-off
  initial begin
    int cyc, hold;
    bit pressured;
    cyc = 0;
    hold = 0;
    pressured = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!pressured && results_seen == 4 && out_valid) begin
        pressured = 1'b1;
        hold = 400;
        out_ready <= 1'b0;
      end else if ((cyc / 97) % 2 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (due_wr == due_rd) begin
        $error("largest_region: unexpected transfer, actual %0d", largest_region);
        errors++;
      end else begin
        logic [RESULT_W-1:0] want;
        want = region_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (largest_region !== want) begin
          $error("largest_region: expected %0d, actual %0d", want, largest_region);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[dilated_grid_largest_region_unit] ERROR");
      $finish;
    end
  end

endmodule

FILE: filelist.f
hw/rtl/dglr_pkg.sv
hw/rtl/dglr_ram.sv
hw/rtl/dilated_grid_largest_region_unit.sv
test/dilated_grid_largest_region_unit_tb.sv
